@@ rtl/stdist_pkg.sv @@
// ----------------------------------------------------------------------------
// stdist_pkg
// shared widths, direction codes and register indexes of the stroke
// template distance block
// ----------------------------------------------------------------------------
package stdist_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int MAX_STROKES = 32;

	localparam int DIR_W     = 18;
	localparam int DIST_W    = 18;
	localparam int STROKES_W = 6;
	localparam int SUM_W     = 32;
	localparam int CNT_W     = $clog2(MAX_POINTS + 1);
	localparam int DIV_W     = (CNT_W > STROKES_W) ? CNT_W : STROKES_W;
	localparam int LIMIT_W   = 20;
	localparam int ACCEPT_W  = 21;
	localparam int EXTRA_W   = 3;
	localparam int SCORE_W   = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 21;

	localparam int DIR_VERTICAL      = 100100;
	localparam int DIR_HORIZONTAL    = 100200;
	localparam int DIR_SMALL         = 10;
	localparam int EXTRA_STROKE_COST = 100;

	localparam logic [LIMIT_W-1:0]  STROKE_LIMIT_RST = LIMIT_W'(3500);
	localparam logic [ACCEPT_W-1:0] ACCEPT_LIMIT_RST = ACCEPT_W'(20000);
	localparam logic [EXTRA_W-1:0]  MAX_EXTRA_RST    = EXTRA_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STROKE_LIMIT = 2'd0,
		REG_ACCEPT_LIMIT = 2'd1,
		REG_MAX_EXTRA    = 2'd2
	} reg_index_t;

endpackage

@@ rtl/stdist_div.sv @@
// ----------------------------------------------------------------------------
// stdist_div
// bit-serial restoring divider, one quotient bit per cycle; the dividend
// shifts out of the top of the quotient register as quotient bits shift in
// ----------------------------------------------------------------------------
module stdist_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [stdist_pkg::SUM_W-1:0]   dividend,
	input  logic [stdist_pkg::DIV_W-1:0]   divisor,
	output logic                           done,
	output logic [stdist_pkg::SUM_W-1:0]   quotient
);
	import stdist_pkg::*;

	localparam int ITER_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DIV_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(SUM_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/stdist_acc.sv @@
// ----------------------------------------------------------------------------
// stdist_acc
// pair distance and per-stroke accumulation of distance sum and pair count
// ----------------------------------------------------------------------------
module stdist_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                stroke_end,
	input  logic                                first,
	input  logic signed [stdist_pkg::DIR_W-1:0] query_direction,
	input  logic signed [stdist_pkg::DIR_W-1:0] template_direction,
	output logic [stdist_pkg::SUM_W-1:0]        sum_next,
	output logic [stdist_pkg::CNT_W-1:0]        cnt_next
);
	import stdist_pkg::*;

	localparam logic signed [DIR_W-1:0] VERT  = DIR_W'(DIR_VERTICAL);
	localparam logic signed [DIR_W-1:0] HORP  = DIR_W'(DIR_HORIZONTAL);
	localparam logic signed [DIR_W-1:0] HORN  = DIR_W'(-DIR_HORIZONTAL);
	localparam logic signed [DIR_W-1:0] SMALL = DIR_W'(DIR_SMALL);

	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    qh;
	logic                    th;
	logic                    both_vert;
	logic signed [DIR_W-1:0] qq;
	logic signed [DIR_W-1:0] tt;
	logic signed [DIR_W:0]   diff;
	logic [DIR_W:0]          mag;
	logic [DIST_W-1:0]       pair_gap;
	logic [SUM_W-1:0]        base_sum;
	logic [CNT_W-1:0]        base_cnt;
	logic [SUM_W:0]          wide_sum;

	always_comb begin
		qh        = (query_direction == HORP) || (query_direction == HORN);
		th        = (template_direction == HORP) || (template_direction == HORN);
		both_vert = !first && (query_direction == VERT) && (template_direction == VERT);
		qq        = (!first && qh && !th) ? SMALL : query_direction;
		tt        = (!first && th && !qh) ? SMALL : template_direction;
		diff      = {qq[DIR_W-1], qq} - {tt[DIR_W-1], tt};
		mag       = diff[DIR_W] ? (DIR_W+1)'(-diff) : diff;
		pair_gap  = both_vert ? DIST_W'(DIR_SMALL) : mag[DIST_W-1:0];

		base_sum = first ? '0 : sum_q;
		base_cnt = first ? '0 : cnt_q;
		wide_sum = {1'b0, base_sum} + (SUM_W+1)'(pair_gap);
		if (base_cnt < CNT_W'(MAX_POINTS)) begin
			sum_next = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
			cnt_next = base_cnt + 1'b1;
		end else begin
			sum_next = base_sum;
			cnt_next = base_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (en) begin
			if (stroke_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

@@ rtl/stroke_template_distance.sv @@
// ----------------------------------------------------------------------------
// stroke_template_distance
// scores a handwritten character against one template from aligned pairs of
// stroke directions
// ----------------------------------------------------------------------------
// A pair that does not end a stroke is taken while the block stays idle, so pairs
// inside a stroke stream at one per cycle. A pair that ends a stroke starts the shared
// bit-serial divider, which gives one quotient bit per cycle: the input stays
// closed while the stroke mean is formed. The pair that ends the character
// adds a second pass of the same divider for the character mean, and the finish
// state then loads the result register. The result waits in its own register,
// so the next character can start while it has not yet been taken.
module stroke_template_distance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stdist_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stdist_pkg::CFG_W-1:0]      cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// query_direction, template_direction, query_strokes, template_strokes
	input  logic [47:0]                       s_tdata,
	// first_of_stroke, last_of_stroke
	input  logic [1:0]                        s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// score, zero fill
	output logic [23:0]                       m_tdata,
	// rejected, accepted
	output logic [1:0]                        m_tuser
);
	import stdist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_STROKE,
		ST_DIV_CHAR,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [LIMIT_W-1:0]    stroke_limit_q;
	logic [ACCEPT_W-1:0]   accept_limit_q;
	logic [EXTRA_W-1:0]    max_extra_q;
	logic [SUM_W-1:0]      char_sum_q;
	logic                  reject_q;
	logic                  lchar_q;
	logic [STROKES_W-1:0]  qs_q;
	logic [STROKES_W-1:0]  ts_q;
	logic                  m_tvalid_q;
	logic [SCORE_W-1:0]    score_q;
	logic                  rejected_q;
	logic                  accepted_q;

	logic                  take;
	logic                  stroke_end;
	logic [SUM_W-1:0]      sum_next;
	logic [CNT_W-1:0]      cnt_next;
	logic                  div_start;
	logic                  div_done;
	logic [SUM_W-1:0]      div_dividend;
	logic [DIV_W-1:0]      div_divisor;
	logic [SUM_W-1:0]      quotient;
	logic                  over_limit;
	logic [SUM_W:0]        char_wide;
	logic [SUM_W-1:0]      char_sum_next;
	logic                  rej;
	logic [EXTRA_W-1:0]    extra;
	logic [SUM_W:0]        score_wide;
	logic [SCORE_W-1:0]    score;
	logic                  out_free;

	assign s_tready   = (state_q == ST_IDLE);
	assign take       = s_tvalid && s_tready;
	assign stroke_end = s_tuser[1] || s_tlast;
	assign out_free   = !m_tvalid_q || m_tready;

	stdist_acc u_acc (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (take),
		.stroke_end         (stroke_end),
		.first              (s_tuser[0]),
		.query_direction    (s_tdata[17:0]),
		.template_direction (s_tdata[35:18]),
		.sum_next           (sum_next),
		.cnt_next           (cnt_next)
	);

	always_comb begin
		over_limit    = (quotient > SUM_W'(stroke_limit_q));
		char_wide     = {1'b0, char_sum_q} + {1'b0, quotient};
		char_sum_next = over_limit ? char_sum_q :
		                (char_wide[SUM_W] ? '1 : char_wide[SUM_W-1:0]);

		div_start    = (take && stroke_end) ||
		               ((state_q == ST_DIV_STROKE) && div_done && lchar_q);
		div_dividend = (state_q == ST_IDLE) ? sum_next : char_sum_next;
		div_divisor  = (state_q == ST_IDLE) ? DIV_W'(cnt_next) : DIV_W'(qs_q);

		rej = reject_q || (qs_q == '0) || (qs_q > STROKES_W'(MAX_STROKES)) ||
		      (ts_q < qs_q) ||
		      ({1'b0, ts_q} > ({1'b0, qs_q} + (STROKES_W+1)'(max_extra_q)));
		extra      = EXTRA_W'(ts_q - qs_q);
		score_wide = {1'b0, quotient} + (SUM_W+1)'(EXTRA_STROKE_COST * extra);
		if (rej) begin
			score = '0;
		end else if (score_wide > (SUM_W+1)'({SCORE_W{1'b1}})) begin
			score = '1;
		end else begin
			score = score_wide[SCORE_W-1:0];
		end
	end

	stdist_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_limit_q <= STROKE_LIMIT_RST;
			accept_limit_q <= ACCEPT_LIMIT_RST;
			max_extra_q    <= MAX_EXTRA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STROKE_LIMIT: stroke_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_ACCEPT_LIMIT: accept_limit_q <= cfg_data[ACCEPT_W-1:0];
				REG_MAX_EXTRA:    max_extra_q    <= cfg_data[EXTRA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			char_sum_q <= '0;
			reject_q   <= 1'b0;
			lchar_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && stroke_end) begin
						lchar_q <= s_tlast;
						state_q <= ST_DIV_STROKE;
					end
				end
				ST_DIV_STROKE: begin
					if (div_done) begin
						char_sum_q <= char_sum_next;
						if (over_limit) begin
							reject_q <= 1'b1;
						end
						state_q <= lchar_q ? ST_DIV_CHAR : ST_IDLE;
					end
				end
				ST_DIV_CHAR: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						char_sum_q <= '0;
						reject_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && stroke_end) begin
			qs_q <= s_tdata[41:36];
			ts_q <= s_tdata[47:42];
		end
		if ((state_q == ST_FINISH) && out_free) begin
			score_q    <= score;
			rejected_q <= rej;
			accepted_q <= !rej && (score < accept_limit_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(24 - SCORE_W){1'b0}}, score_q};
	assign m_tuser  = {accepted_q, rejected_q};

	a_end_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		take && stroke_end |=> state_q == ST_DIV_STROKE)
		else $error("stroke end did not start the divider");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_STROKE || state_q == ST_DIV_CHAR))
		else $error("divider finished outside a divide state");

	a_rej_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result both rejected and accepted");

	a_rej_zero_score: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("rejected result carries a score");

endmodule

@@ verif/tb_stroke_template_distance.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stroke_template_distance
// self-checking bench for the stroke template distance block
// ----------------------------------------------------------------------------
// Streams aligned direction pairs, grouped into strokes and characters, into
// the block and predicts each character score in a small scoring class that
// tracks the stroke sums, the stroke means and the reject state. A directed
// run covers the direction codes, the stroke count window and the restart and
// end cases. Random phases follow, each under its own register setting and
// a pattern of source gaps and sink stalls. Every score transfer is
// compared field by field with the oldest predicted score.
// ----------------------------------------------------------------------------
module tb_stroke_template_distance;

	import stdist_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 100;
	localparam int PHASE_ITEMS = 216;
	localparam longint unsigned SUM_SAT   = 64'hFFFF_FFFF;
	localparam longint unsigned SCORE_SAT = 64'd2097151;

	typedef struct {
		logic [DIR_W-1:0]     qdir;
		logic [DIR_W-1:0]     tdir;
		logic                 first;
		logic                 lstroke;
		logic                 lchar;
		logic [STROKES_W-1:0] qs;
		logic [STROKES_W-1:0] ts;
	} dir_pair_t;

	typedef struct {
		logic [SCORE_W-1:0] score;
		logic               rejected;
		logic               accepted;
	} char_score_t;

	class char_scorer;
		logic [LIMIT_W-1:0]  stroke_limit;
		logic [ACCEPT_W-1:0] accept_limit;
		logic [EXTRA_W-1:0]  max_extra;
		longint unsigned     stroke_sum;
		longint unsigned     char_sum;
		int                  pair_count;
		bit                  reject_flag;
		char_score_t         pending[$];
		int                  errors;

		function new();
			stroke_limit = STROKE_LIMIT_RST;
			accept_limit = ACCEPT_LIMIT_RST;
			max_extra    = MAX_EXTRA_RST;
			errors       = 0;
			clear_char();
		endfunction

		function void clear_char();
			stroke_sum  = 0;
			char_sum    = 0;
			pair_count  = 0;
			reject_flag = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_STROKE_LIMIT: stroke_limit = v[LIMIT_W-1:0];
				REG_ACCEPT_LIMIT: accept_limit = v[ACCEPT_W-1:0];
				REG_MAX_EXTRA:    max_extra    = v[EXTRA_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned sat32(longint unsigned v);
			return (v > SUM_SAT) ? SUM_SAT : v;
		endfunction

		function longint direction_gap(longint q, longint t, bit first);
			bit qh;
			bit th;
			qh = (q == DIR_HORIZONTAL) || (q == -DIR_HORIZONTAL);
			th = (t == DIR_HORIZONTAL) || (t == -DIR_HORIZONTAL);
			if (!first) begin
				if (q == DIR_VERTICAL && t == DIR_VERTICAL)
					return DIR_SMALL;
				if (!(qh && th)) begin
					if (qh) q = DIR_SMALL;
					if (th) t = DIR_SMALL;
				end
			end
			return (q > t) ? q - t : t - q;
		endfunction

		function void take_pair(dir_pair_t p);
			logic signed [DIR_W-1:0] qsig;
			logic signed [DIR_W-1:0] tsig;
			longint                  q;
			longint                  t;
			longint unsigned         mean;
			longint unsigned         total;
			int                      qn;
			int                      tn;
			bit                      rej;
			char_score_t             r;
			qsig = p.qdir;
			tsig = p.tdir;
			q = qsig;
			t = tsig;
			if (p.first) begin
				stroke_sum = 0;
				pair_count = 0;
			end
			if (pair_count < MAX_POINTS) begin
				stroke_sum = sat32(stroke_sum + longint'(direction_gap(q, t, p.first)));
				pair_count++;
			end
			if (p.lstroke || p.lchar) begin
				if (pair_count != 0) begin
					mean = stroke_sum / pair_count;
					if (mean > stroke_limit)
						reject_flag = 1;
					else
						char_sum = sat32(char_sum + mean);
				end
				stroke_sum = 0;
				pair_count = 0;
			end
			if (!p.lchar)
				return;
			qn    = p.qs;
			tn    = p.ts;
			rej   = reject_flag;
			total = 0;
			if (qn == 0 || qn > MAX_STROKES)
				rej = 1;
			if (tn < qn || tn > qn + int'(max_extra))
				rej = 1;
			if (!rej) begin
				total = char_sum / qn + longint'(EXTRA_STROKE_COST * (tn - qn));
				if (total > SCORE_SAT)
					total = SCORE_SAT;
			end
			r.score    = SCORE_W'(total);
			r.rejected = rej;
			r.accepted = !rej && (total < accept_limit);
			pending = {pending, r};
			clear_char();
		endfunction

		function void match_score(char_score_t got);
			char_score_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected score transfer: score %0d rejected %0b accepted %0b",
						got.score, got.rejected, got.accepted);
				return;
			end
			want = pending.pop_front();
			if (got.score !== want.score || got.rejected !== want.rejected ||
					got.accepted !== want.accepted) begin
				errors++;
				if (errors <= 10)
					$display("score mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
						want.score, want.rejected, want.accepted,
						got.score, got.rejected, got.accepted);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic [1:0]            s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;
	logic [1:0]            m_tuser;

	char_scorer  scorer;
	char_score_t seen;
	int          send_idle;
	int          recv_stall;
	int          items_sent;
	int          cycle_count;

	stroke_template_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.score    = m_tdata[SCORE_W-1:0];
			seen.rejected = m_tuser[0];
			seen.accepted = m_tuser[1];
			scorer.match_score(seen);
		end
	end

	task automatic send_pair(dir_pair_t p);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.ts, p.qs, p.tdir, p.qdir};
		s_tuser  <= {p.lstroke, p.first};
		s_tlast  <= p.lchar;
		do
			@(posedge clk);
		while (!s_tready);
		scorer.take_pair(p);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(int q, int t, bit first, bit ls, bit lc, int qs, int ts);
		dir_pair_t p;
		p.qdir    = DIR_W'(q);
		p.tdir    = DIR_W'(t);
		p.first   = first;
		p.lstroke = ls;
		p.lchar   = lc;
		p.qs      = STROKES_W'(qs);
		p.ts      = STROKES_W'(ts);
		send_pair(p);
	endtask

	task automatic write_regs(int unsigned sl, int unsigned al, int unsigned me);
		reg_index_t idx[3];
		logic [CFG_W-1:0] val[3];
		idx = '{REG_STROKE_LIMIT, REG_ACCEPT_LIMIT, REG_MAX_EXTRA};
		val = '{CFG_W'(sl), CFG_W'(al), CFG_W'(me)};
		for (int i = 0; i < 3; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			scorer.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (scorer.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic int pick_direction();
		case ($urandom_range(9))
			0: return DIR_VERTICAL;
			1: return DIR_HORIZONTAL;
			2: return -DIR_HORIZONTAL;
			3: return int'($urandom_range(262143)) - 131072;
			default: return int'($urandom_range(200400)) - 100200;
		endcase
	endfunction

	function automatic int pick_partner(int q);
		int t;
		case ($urandom_range(9))
			0, 1: return pick_direction();
			2: return q;
			default: begin
				t = q + int'($urandom_range(4000)) - 2000;
				if (t > DIR_HORIZONTAL) t = DIR_HORIZONTAL;
				if (t < -DIR_HORIZONTAL) t = -DIR_HORIZONTAL;
				return t;
			end
		endcase
	endfunction

	// one character: mostly well formed, with missing or extra stroke marks
	task automatic send_character();
		int  r;
		int  qs;
		int  ts;
		int  nstrokes;
		int  len;
		int  q;
		bit  first;
		bit  ls;
		bit  lc;
		r = $urandom_range(99);
		if (r < 88)
			qs = $urandom_range(1, 4);
		else if (r < 93)
			qs = $urandom_range(5, 32);
		else if (r < 96)
			qs = 0;
		else
			qs = $urandom_range(33, 63);
		r = $urandom_range(99);
		if (r < 70)
			ts = qs + $urandom_range(0, scorer.max_extra);
		else if (r < 78)
			ts = qs + scorer.max_extra + 1;
		else if (r < 85)
			ts = qs - 1;
		else
			ts = $urandom_range(0, 63);
		ts = ts & 63;
		nstrokes = (qs >= 1 && qs <= MAX_STROKES) ? qs : $urandom_range(1, 3);
		for (int s = 0; s < nstrokes; s++) begin
			r = $urandom_range(99);
			if (r < 90)
				len = $urandom_range(1, 6);
			else if (r < 97)
				len = $urandom_range(7, 20);
			else
				len = $urandom_range(MAX_POINTS - 2, MAX_POINTS + 6);
			for (int i = 0; i < len; i++) begin
				q     = pick_direction();
				first = (i == 0) ? ($urandom_range(99) < 97) : ($urandom_range(99) < 2);
				ls    = (i == len - 1) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 1);
				lc    = (s == nstrokes - 1 && i == len - 1) || ($urandom_range(999) < 3);
				send_fields(q, pick_partner(q), first, ls, lc, qs, ts);
			end
		end
	endtask

	task automatic directed_run();
		// direction codes, first pair plain difference, 18-bit extremes
		send_fields(-DIR_HORIZONTAL, DIR_HORIZONTAL, 1, 0, 0, 1, 1);
		send_fields(DIR_VERTICAL, DIR_VERTICAL, 0, 0, 0, 1, 1);
		send_fields(DIR_HORIZONTAL, -DIR_HORIZONTAL, 0, 0, 0, 1, 1);
		send_fields(DIR_HORIZONTAL, 5, 0, 0, 0, 1, 1);
		send_fields(DIR_VERTICAL, 0, 0, 0, 0, 1, 1);
		send_fields(-131072, 131071, 0, 1, 1, 1, 1);
		// accepted character, ends without a stroke end mark
		send_fields(0, 0, 1, 0, 0, 2, 4);
		send_fields(100, 50, 0, 1, 0, 2, 4);
		send_fields(DIR_VERTICAL, DIR_VERTICAL, 1, 0, 0, 2, 4);
		send_fields(DIR_SMALL, DIR_HORIZONTAL, 0, 0, 1, 2, 4);
		// restart within a stroke, template has fewer strokes
		send_fields(0, 3000, 1, 0, 0, 1, 0);
		send_fields(0, 0, 1, 0, 0, 1, 0);
		send_fields(7, 3, 0, 1, 1, 1, 0);
		// bad query stroke counts, too many template strokes, both counts at their limits
		send_fields(0, 0, 1, 1, 1, 0, 0);
		send_fields(0, 0, 1, 1, 1, 33, 33);
		send_fields(0, 0, 1, 1, 1, 63, 63);
		send_fields(0, 0, 1, 1, 1, 1, 4);
		send_fields(-100, 100, 1, 1, 1, 32, 34);
	endtask

	initial begin
		scorer     = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		s_tlast    = 1'b0;
		send_idle  = 0;
		recv_stall = 0;
		items_sent = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_run();
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
					write_regs(1048575, 2097151, 7);
				end
				1: begin
					send_idle  = 61;
					recv_stall = 0;
					write_regs(0, 0, 0);
				end
				2: begin
					send_idle  = 0;
					recv_stall = 61;
					write_regs($urandom_range(1000, 20000), $urandom_range(0, 80000),
						$urandom_range(0, 7));
				end
				3: begin
					send_idle  = 31;
					recv_stall = 31;
					write_regs($urandom_range(0, 1048575), $urandom_range(0, 2097151),
						$urandom_range(0, 7));
				end
				default: begin
					send_idle  = 31;
					recv_stall = 31;
					write_regs(3500, 20000, 2);
				end
			endcase
			begin
				int target;
				target = items_sent + PHASE_ITEMS;
				while (items_sent < target)
					send_character();
			end
			drain();
		end

		if (scorer.errors == 0 && scorer.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/stdist_pkg.sv
rtl/stdist_div.sv
rtl/stdist_acc.sv
rtl/stroke_template_distance.sv
verif/tb_stroke_template_distance.sv
